@@ rtl/core/tpo_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle pair overlap package
// Shared constants and the control word handed from cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package tpo_pkg;

  localparam int NUM_VERTS  = 3;
  localparam int NUM_TRIS   = 2;
  localparam int NUM_POINTS = NUM_TRIS * NUM_VERTS;
  localparam int NUM_COORDS = 2 * NUM_POINTS;
  localparam int NUM_AXES   = NUM_TRIS * NUM_VERTS;

  typedef struct packed {
    logic valid;
    logic hit;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/tpo_axis_cell.sv @@
// ----------------------------------------------------------------------------
// Triangle pair overlap axis cell
// Tests one edge normal in two registered stages: projections, then the
// interval comparison, and clears the running hit flag on separation.
// ----------------------------------------------------------------------------
`default_nettype none

module tpo_axis_cell #(
  parameter int COORD_BITS = 12,
  parameter int EDGE_TRI   = 0,
  parameter int EDGE_IDX   = 0
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire tpo_pkg::ctl_t                         up_ctl,
  input  wire [tpo_pkg::NUM_COORDS*COORD_BITS-1:0]   up_coords,
  output logic                                       up_en,
  output tpo_pkg::ctl_t                              down_ctl,
  output logic [tpo_pkg::NUM_COORDS*COORD_BITS-1:0]  down_coords,
  input  wire                                        down_en
);
  import tpo_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = 2 * CW + 2;
  localparam int DW = 2 * CW + 3;
  localparam int VW = NUM_COORDS * CW;
  localparam int VI = EDGE_TRI * NUM_VERTS + EDGE_IDX;
  localparam int VJ = EDGE_TRI * NUM_VERTS + (EDGE_IDX + 1) % NUM_VERTS;

  logic signed [CW:0]   xs [NUM_POINTS];
  logic signed [CW:0]   ys [NUM_POINTS];
  logic signed [CW:0]   nx;
  logic signed [CW:0]   ny;
  logic signed [PW-1:0] prod_x [NUM_POINTS];
  logic signed [PW-1:0] prod_y [NUM_POINTS];
  logic signed [DW-1:0] dot_nxt [NUM_POINTS];

  logic signed [DW-1:0] dot_r [NUM_POINTS];
  logic [VW-1:0]        coords_a_r;
  logic                 valid_a_r;
  logic                 hit_a_r;
  logic [VW-1:0]        coords_b_r;
  logic                 valid_b_r;
  logic                 hit_b_r;
  logic                 hit_b_nxt;

  logic                 en_a;
  logic                 en_b;

  logic signed [DW-1:0] a_lo;
  logic signed [DW-1:0] a_hi;
  logic signed [DW-1:0] b_lo;
  logic signed [DW-1:0] b_hi;
  logic                 sep;

  assign en_b  = !valid_b_r || down_en;
  assign en_a  = !valid_a_r || en_b;
  assign up_en = en_a;

  for (genvar v = 0; v < NUM_POINTS; v++) begin : g_proj
    assign xs[v]      = signed'({1'b0, up_coords[(2 * v) * CW +: CW]});
    assign ys[v]      = signed'({1'b0, up_coords[(2 * v + 1) * CW +: CW]});
    assign prod_x[v]  = PW'(xs[v]) * PW'(nx);
    assign prod_y[v]  = PW'(ys[v]) * PW'(ny);
    assign dot_nxt[v] = DW'(prod_x[v]) + DW'(prod_y[v]);
  end

  // The normal is the edge rotated by a quarter turn: (dx, dy) -> (-dy, dx).
  assign nx = ys[VI] - ys[VJ];
  assign ny = xs[VJ] - xs[VI];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en_a) begin
      valid_a_r <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      hit_a_r    <= up_ctl.hit;
      coords_a_r <= up_coords;
      for (int v = 0; v < NUM_POINTS; v++) begin
        dot_r[v] <= dot_nxt[v];
      end
    end
  end

  always_comb begin
    a_lo = dot_r[0];
    a_hi = dot_r[0];
    b_lo = dot_r[NUM_VERTS];
    b_hi = dot_r[NUM_VERTS];
    for (int v = 1; v < NUM_VERTS; v++) begin
      if (dot_r[v] < a_lo) begin
        a_lo = dot_r[v];
      end
      if (dot_r[v] > a_hi) begin
        a_hi = dot_r[v];
      end
      if (dot_r[NUM_VERTS + v] < b_lo) begin
        b_lo = dot_r[NUM_VERTS + v];
      end
      if (dot_r[NUM_VERTS + v] > b_hi) begin
        b_hi = dot_r[NUM_VERTS + v];
      end
    end
    // Touching intervals count as overlap, so only strict gaps separate.
    sep       = (b_lo > a_hi) || (a_lo > b_hi);
    hit_b_nxt = hit_a_r && !sep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (en_b) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      hit_b_r    <= hit_b_nxt;
      coords_b_r <= coords_a_r;
    end
  end

  assign down_ctl.valid = valid_b_r;
  assign down_ctl.hit   = hit_b_r;
  assign down_coords    = coords_b_r;

`ifndef SYNTHESIS
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    valid_b_r && !down_en |=> valid_b_r && $stable(hit_b_r) && $stable(coords_b_r))
    else $error("axis cell result changed while blocked");

  a_miss_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    en_b && valid_a_r && !hit_a_r |=> !hit_b_r)
    else $error("axis cell revived a separated pair");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_a_r |-> up_en)
    else $error("axis cell refused a transfer with its first stage empty");
`endif

endmodule

`default_nettype wire

@@ rtl/core/triangle_pair_overlap_sat.sv @@
// ----------------------------------------------------------------------------
// Triangle pair overlap, separating axis test
// Chain of six axis cells deciding whether two 2D triangles overlap.
// ----------------------------------------------------------------------------
// Usage: one input transfer carries both triangles as twelve unsigned
// coordinates (in_a_x0 .. in_b_y2). Each transfer yields exactly one result
// transfer on out_colliding, high when no edge normal separates the pair;
// touching counts as overlap.
// Each input transfer passes through six cells, one per edge of the two
// triangles, each with a projection stage (two multiplies and an add per
// vertex) and a compare stage; the last compare stage drives the out_ ports.
// Throughput is one item per cycle while out_stall is low.
// Every stage holds its item until the next stage can take it, so bubbles
// close up and in_stall rises only once all twelve stages are full and
// out_stall is high. A stalled result stays on the out_ ports unchanged.
// Synchronous reset empties the pipeline; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_pair_overlap_sat #(
  parameter int COORD_BITS = 12
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [COORD_BITS-1:0] in_a_x0,
  input  wire [COORD_BITS-1:0] in_a_y0,
  input  wire [COORD_BITS-1:0] in_a_x1,
  input  wire [COORD_BITS-1:0] in_a_y1,
  input  wire [COORD_BITS-1:0] in_a_x2,
  input  wire [COORD_BITS-1:0] in_a_y2,
  input  wire [COORD_BITS-1:0] in_b_x0,
  input  wire [COORD_BITS-1:0] in_b_y0,
  input  wire [COORD_BITS-1:0] in_b_x1,
  input  wire [COORD_BITS-1:0] in_b_y1,
  input  wire [COORD_BITS-1:0] in_b_x2,
  input  wire [COORD_BITS-1:0] in_b_y2,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_colliding
);
  import tpo_pkg::*;

  localparam int VW = NUM_COORDS * COORD_BITS;

  ctl_t          ctl    [NUM_AXES + 1];
  logic [VW-1:0] coords [NUM_AXES + 1];
  logic          en     [NUM_AXES + 1];

  assign ctl[0].valid = in_valid;
  assign ctl[0].hit   = 1'b1;
  assign coords[0]    = {in_b_y2, in_b_x2, in_b_y1, in_b_x1, in_b_y0, in_b_x0,
                         in_a_y2, in_a_x2, in_a_y1, in_a_x1, in_a_y0, in_a_x0};
  assign en[NUM_AXES] = !out_stall;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
    tpo_axis_cell #(
      .COORD_BITS (COORD_BITS),
      .EDGE_TRI   (k / NUM_VERTS),
      .EDGE_IDX   (k % NUM_VERTS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .up_ctl      (ctl[k]),
      .up_coords   (coords[k]),
      .up_en       (en[k]),
      .down_ctl    (ctl[k + 1]),
      .down_coords (coords[k + 1]),
      .down_en     (en[k + 1])
    );
  end

  assign in_stall      = !en[0];
  assign out_valid     = ctl[NUM_AXES].valid;
  assign out_colliding = ctl[NUM_AXES].hit;

`ifndef SYNTHESIS
  a_empty_output_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled although the output register is empty");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  a_free_output_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled although the output side is taking transfers");
`endif

endmodule

`default_nettype wire
